// ===== rtl/swpf_pkg.sv =====
// shared constants and types of the shortest-window peak finder
package swpf_pkg;

  // field widths
  localparam int TIME_BITS = 20;
  localparam int HIT_BITS  = 13;
  localparam int OUT_BITS  = TIME_BITS + 1;

  // hit count is clamped to this before the window length is derived
  localparam logic [HIT_BITS-1:0] MAX_HITS = 13'd4096;

  // isqrt(MAX_HITS) = 64 needs seven bits
  localparam int ROOT_BITS  = 7;
  localparam int STEP_BITS  = $clog2(ROOT_BITS);
  localparam int RING_DEPTH = 2 * (1 << (ROOT_BITS - 1)) + 1;
  localparam int ADDR_BITS  = $clog2(RING_DEPTH);

  // events of up to this many hits report the median
  localparam logic [2:0] SMALL_LIMIT = 3'd5;
  localparam logic [2:0] SMALL_SLOT_LAST = 3'd4;

  // median cases by number of stored hits
  localparam logic [2:0] MED_TWO  = 3'd2;
  localparam logic [2:0] MED_FOUR = 3'd4;

  typedef enum logic {
    ST_RUN,
    ST_ROOT
  } state_t;

  typedef struct packed {
    logic                start;
    logic [HIT_BITS-1:0] count;
  } root_req_t;

  typedef struct packed {
    logic                 done;
    logic [ROOT_BITS-1:0] root;
  } root_res_t;

endpackage

// ===== rtl/shortest_window_peak_finder_core.sv =====
// Shortest-window peak finder: takes the ascending hit times of one event, one
// beat per hit, and after the last hit returns the middle time of the shortest
// window of 2*isqrt(count)+1 consecutive hits (first window wins on ties), in
// half-ticks. Events of five or fewer hits return the median, an even count the
// exact sum of the two middle times; an empty-event beat returns zero. Rate: one
// hit per cycle in steady state. The first hit of each event waits while the
// serial square-root unit (one root bit per cycle) derives the window length.
// Each hit does two reads of the 129-entry ring RAM, and one write unless the
// event is small. The reads are registered, a second stage updates the best
// window, and the output register holds the result. Hits keep flowing while a
// result waits at the output; only a second result stalls behind it.
module shortest_window_peak_finder_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [swpf_pkg::TIME_BITS-1:0] in_hit_time,
  input  logic [swpf_pkg::HIT_BITS-1:0]       in_hit_total,
  input  logic                                in_last_hit,
  input  logic                                in_empty_event,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [swpf_pkg::OUT_BITS-1:0] out_peak_time_halves
);

  localparam int TB = swpf_pkg::TIME_BITS;
  localparam int OB = swpf_pkg::OUT_BITS;
  localparam int AB = swpf_pkg::ADDR_BITS;
  localparam int HB = swpf_pkg::HIT_BITS;

  // control state of the sequencer
  swpf_pkg::state_t state_r, state_nxt;
  swpf_pkg::root_req_t root_req;
  swpf_pkg::root_res_t root_res;

  // per-event state
  logic [HB-1:0] hit_index_r, hit_index_nxt;
  logic [AB-1:0] ring_ptr_r, ring_ptr_nxt;
  logic          small_r, small_nxt;
  logic          win_valid_r, win_valid_nxt;
  logic [AB-1:0] win_len_r, win_len_nxt;
  logic [TB-1:0] slot_r [5];

  // second stage: best-window update and result
  logic          s2_valid_r, s2_valid_nxt;
  logic          s2_first_r, s2_cmp_r, s2_firstwin_r;
  logic          s2_res_r, s2_small_r, s2_empty_r;
  logic [2:0]    s2_count_r;
  logic signed [TB-1:0] s2_time_r;
  logic signed [OB-1:0] best_span_r, best_span_nxt;
  logic signed [TB-1:0] best_mid_r, best_mid_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic signed [OB-1:0] out_data_r, out_data_nxt;

  // first-stage datapath
  logic          accept;
  logic          first_hit;
  logic          need_root;
  logic          s2_adv;
  logic [HB-1:0] count_clamped;
  logic          small_now;
  logic [AB-1:0] wr_ptr;
  logic [AB:0]   ptr_inc;
  logic [AB-1:0] next_ptr;
  logic [AB:0]   mid_sum;
  logic [AB-1:0] mid_ptr;
  logic [HB:0]   hit_inc;
  logic [HB-1:0] hit_sat;
  logic [2:0]    slot_idx;
  logic [2:0]    count_small;
  logic          ring_we;
  logic [TB-1:0] old_time, mid_time;

  // second-stage datapath
  logic signed [OB-1:0] span;
  logic signed [OB-1:0] base_span;
  logic signed [TB-1:0] base_mid;
  logic                 take_window;
  logic signed [OB-1:0] small_result;

  assign count_clamped = (in_hit_total > swpf_pkg::MAX_HITS) ? swpf_pkg::MAX_HITS
                                                             : in_hit_total;
  assign first_hit = (hit_index_r == '0);
  // window length is known only once the root unit has run for this event
  assign need_root = in_valid && !in_empty_event && first_hit && !win_valid_r;

  // stage 2 holds while a result cannot move into a full output register
  assign s2_adv   = !s2_valid_r || !s2_res_r || !out_valid_r || out_ready;
  assign in_ready = (state_r == swpf_pkg::ST_RUN) && !need_root && s2_adv;
  assign accept   = in_valid && in_ready;

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swpf_pkg::ST_RUN:  if (need_root) state_nxt = swpf_pkg::ST_ROOT;
      swpf_pkg::ST_ROOT: if (root_res.done) state_nxt = swpf_pkg::ST_RUN;
      default:           state_nxt = swpf_pkg::ST_RUN;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    root_req.start = 1'b0;
    root_req.count = count_clamped;
    case (state_r)
      swpf_pkg::ST_RUN:  root_req.start = need_root;
      swpf_pkg::ST_ROOT: root_req.start = 1'b0;
      default:           root_req.start = 1'b0;
    endcase
  end

  swpf_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (root_req),
    .res   (root_res)
  );

  // ring addressing: write the newest slot, read the oldest and the middle
  assign small_now = first_hit ? (count_clamped <= HB'(swpf_pkg::SMALL_LIMIT)) : small_r;
  assign wr_ptr    = first_hit ? '0 : ring_ptr_r;
  assign ptr_inc   = {1'b0, wr_ptr} + 1'b1;
  assign next_ptr  = (ptr_inc >= {1'b0, win_len_r}) ? '0 : ptr_inc[AB-1:0];
  assign mid_sum   = {1'b0, next_ptr} + {2'b0, win_len_r[AB-1:1]};
  assign mid_ptr   = (mid_sum >= {1'b0, win_len_r}) ? AB'(mid_sum - {1'b0, win_len_r})
                                                    : mid_sum[AB-1:0];

  // hit counter saturates; only compares against small values follow from it
  assign hit_inc = {1'b0, hit_index_r} + 1'b1;
  assign hit_sat = (&hit_index_r) ? hit_index_r : hit_inc[HB-1:0];
  assign slot_idx = (hit_index_r >= HB'(swpf_pkg::SMALL_SLOT_LAST)) ? swpf_pkg::SMALL_SLOT_LAST
                                                                   : hit_index_r[2:0];
  assign count_small = (hit_sat >= HB'(swpf_pkg::SMALL_LIMIT)) ? swpf_pkg::SMALL_LIMIT
                                                              : hit_sat[2:0];

  assign ring_we = accept && !in_empty_event && !small_now;

  swpf_ring_ram #(
    .DEPTH (swpf_pkg::RING_DEPTH),
    .WIDTH (TB)
  ) u_ring (
    .clk     (clk),
    .we      (ring_we),
    .waddr   (wr_ptr),
    .wdata   (in_hit_time),
    .re      (accept),
    .raddr_a (next_ptr),
    .raddr_b (mid_ptr),
    .rdata_a (old_time),
    .rdata_b (mid_time)
  );

  // per-event control
  always_comb begin
    hit_index_nxt = hit_index_r;
    ring_ptr_nxt  = ring_ptr_r;
    small_nxt     = small_r;
    win_valid_nxt = win_valid_r;
    win_len_nxt   = win_len_r;
    if (state_r == swpf_pkg::ST_ROOT && root_res.done) begin
      win_len_nxt   = {root_res.root, 1'b1};
      win_valid_nxt = 1'b1;
    end
    if (accept) begin
      if (in_empty_event || in_last_hit) begin
        // event closes: start the next one from scratch
        hit_index_nxt = '0;
        ring_ptr_nxt  = '0;
        small_nxt     = 1'b0;
        win_valid_nxt = 1'b0;
      end else begin
        hit_index_nxt = hit_sat;
        small_nxt     = small_now;
        if (!small_now) begin
          ring_ptr_nxt = next_ptr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swpf_pkg::ST_RUN;
      hit_index_r <= '0;
      ring_ptr_r  <= '0;
      small_r     <= 1'b0;
      win_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hit_index_r <= hit_index_nxt;
      ring_ptr_r  <= ring_ptr_nxt;
      small_r     <= small_nxt;
      win_valid_r <= win_valid_nxt;
    end
    win_len_r <= win_len_nxt;
  end

  // small events keep their first five hits, later ones land in the last slot
  always_ff @(posedge clk) begin
    if (accept && !in_empty_event && small_now) begin
      slot_r[slot_idx] <= in_hit_time;
    end
  end

  // hand the hit to stage 2
  assign s2_valid_nxt = accept ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
    if (accept) begin
      s2_first_r    <= first_hit;
      s2_cmp_r      <= !in_empty_event && !small_now && (hit_inc >= {6'b0, win_len_r});
      s2_firstwin_r <= (hit_inc == {6'b0, win_len_r});
      s2_res_r      <= in_last_hit || in_empty_event;
      s2_small_r    <= small_now;
      s2_empty_r    <= in_empty_event;
      s2_count_r    <= count_small;
      s2_time_r     <= in_hit_time;
    end
  end

  // stage 2: span of the window that ends at this hit against the best so far
  assign span      = OB'(s2_time_r) - OB'($signed(old_time));
  assign base_span = s2_first_r ? '0 : best_span_r;
  assign base_mid  = s2_first_r ? '0 : best_mid_r;
  assign take_window = s2_cmp_r && (s2_firstwin_r || (span < base_span));

  always_comb begin
    best_span_nxt = take_window ? span : base_span;
    best_mid_nxt  = take_window ? $signed(mid_time) : base_mid;
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r && s2_adv && !s2_empty_r) begin
      best_span_r <= best_span_nxt;
      best_mid_r  <= best_mid_nxt;
    end
  end

  // median of up to five stored hits, in half-ticks
  always_comb begin
    case (s2_count_r)
      swpf_pkg::MED_TWO:  small_result = OB'($signed(slot_r[0])) + OB'($signed(slot_r[1]));
      swpf_pkg::MED_FOUR: small_result = OB'($signed(slot_r[1])) + OB'($signed(slot_r[2]));
      3'd3:               small_result = {slot_r[1], 1'b0};
      swpf_pkg::SMALL_LIMIT: small_result = {slot_r[2], 1'b0};
      default:            small_result = {slot_r[0], 1'b0};
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s2_valid_r && s2_res_r && s2_adv) begin
      out_valid_nxt = 1'b1;
      if (s2_empty_r) begin
        out_data_nxt = '0;
      end else if (s2_small_r) begin
        out_data_nxt = small_result;
      end else begin
        out_data_nxt = {best_mid_nxt, 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_peak_time_halves = out_data_r;

endmodule

// ===== rtl/swpf_isqrt.sv =====
// serial integer square root, one result bit per cycle
module swpf_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  swpf_pkg::root_req_t req,
  output swpf_pkg::root_res_t res
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [swpf_pkg::STEP_BITS-1:0]      step_r, step_nxt;
  logic [swpf_pkg::ROOT_BITS-1:0]      root_r, root_nxt;
  logic [swpf_pkg::HIT_BITS-1:0]       count_r, count_nxt;
  logic [swpf_pkg::ROOT_BITS-1:0]      trial;
  logic [2*swpf_pkg::ROOT_BITS-1:0]    trial_sq;

  // try setting the current bit, keep it when the square still fits
  assign trial    = root_r | (swpf_pkg::ROOT_BITS'(1) << step_r);
  assign trial_sq = trial * trial;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    step_nxt  = step_r;
    root_nxt  = root_r;
    count_nxt = count_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      step_nxt  = swpf_pkg::STEP_BITS'(swpf_pkg::ROOT_BITS - 1);
      root_nxt  = '0;
      count_nxt = req.count;
    end else if (busy_r) begin
      if (trial_sq <= (2*swpf_pkg::ROOT_BITS)'(count_r)) begin
        root_nxt = trial;
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r  <= step_nxt;
    root_r  <= root_nxt;
    count_r <= count_nxt;
  end

  assign res.done = done_r;
  assign res.root = root_r;

endmodule

// ===== rtl/swpf_ring_ram.sv =====
// ring memory: one write port, two registered read ports
module swpf_ring_ram #(
  parameter int DEPTH = 129,
  parameter int WIDTH = 20,
  parameter int ABITS = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [ABITS-1:0] raddr_a,
  input  logic [ABITS-1:0] raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/swpf_checker.sv =====
// port-level checks of the peak finder, bound to the top level
module swpf_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 in_last_hit,
  input logic                                 in_empty_event,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [swpf_pkg::OUT_BITS-1:0] out_peak_time_halves
);

  logic [1:0] pend_r, pend_nxt;
  logic       res_in, res_out;

  // results owed: beats that close an event minus result beats delivered
  assign res_in  = in_valid && in_ready && (in_last_hit || in_empty_event);
  assign res_out = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (res_in && !res_out && pend_r != 2'd3) begin
      pend_nxt = pend_r + 1'b1;
    end else if (!res_in && res_out && pend_r != 2'd0) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_peak_time_halves))
    else $error("result beat changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result beat without a closing hit");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 2'd2)
    else $error("more than two results held inside");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_peak_time_halves != 21'sh0FFFFF)
    else $error("peak time outside the range of two hit times");

endmodule

bind shortest_window_peak_finder_core swpf_checker u_swpf_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .in_last_hit          (in_last_hit),
  .in_empty_event       (in_empty_event),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_peak_time_halves (out_peak_time_halves)
);
